// ===== rtl/core/cspi_pkg.sv =====
// ----------------------------------------------------------------------------
// cspi_pkg: shared types and constants of the PI clock servo
// Item layouts, register indexes, mode codes and fixed-point constants.
// ----------------------------------------------------------------------------
package cspi_pkg;

    localparam int TIME_W    = 64;
    localparam int FRAC_BITS = 40;
    localparam int RATIO_W   = FRAC_BITS + 2;
    localparam int ERR_W     = 48;
    localparam int PROD_W    = 2 * TIME_W;
    localparam int GAIN_W    = 24;
    localparam int WEIGHT_W  = 16;
    localparam int LIMIT_W   = 41;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_LIMIT    = 3'd4;

    // operation selector
    localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONVERT = 2'd2;

    // reset values of registers and state
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 24'd2516582;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST    = 24'd251658;
    localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 16'd6554;
    localparam logic [LIMIT_W-1:0]  INTEG_LIMIT_RST   = 41'd500000000;
    localparam logic [LIMIT_W-1:0]  CORR_LIMIT_RST    = 41'd5497558139;
    localparam logic [RATIO_W-1:0]  ONE_RATIO         = RATIO_W'(1) << FRAC_BITS;

    // saturation caps and divisors
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] RATIO_CAP = TIME_W'({RATIO_W{1'b1}});
    localparam logic [TIME_W-1:0] ERR_CAP   = TIME_W'({ERR_W{1'b1}});
    localparam logic [TIME_W-1:0] STEP_CAP  = TIME_W'(1) << 62;
    localparam logic [TIME_W-1:0] TERM_CAP  = TIME_W'(1) << 54;
    localparam logic [TIME_W-1:0] NS_PER_S  = 64'd1000000000;
    localparam logic [TIME_W-1:0] GAIN_DIV  = NS_PER_S << GAIN_W;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] master_time;
        logic [TIME_W-1:0] ref_time;
        logic [TIME_W-1:0] duration;
    } cspi_in_t;

    typedef struct packed {
        logic [TIME_W-1:0]  slave_time;
        logic [TIME_W-1:0]  ref_duration;
        logic [RATIO_W-1:0] rate_now;
        logic [ERR_W-1:0]   jitter_ns;
        logic [ERR_W-1:0]   max_error_ns;
        logic               applied;
    } cspi_out_t;

    // status of a sequenced arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } cspi_stat_t;

endpackage

// ===== rtl/core/clock_slave_pi_servo.sv =====
// ----------------------------------------------------------------------------
// clock_slave_pi_servo: PI servo locking a slave timescale to a master clock
// Sample, projection and duration conversion over one shared serial
// multiplier and one shared serial divider.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid / in_ready   | in_data  (mode, times, dur)
//   out     | output    | out_valid / out_ready | out_data (slave time, stats)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item is in work at a time. A read (mode 1) runs one multiply in the
// shift-add multiplier, a duration conversion (mode 2) at most one divide in
// the restoring divider, and a loop-update sample four of each. The finished
// item waits in the output register; the next item is taken while it waits.
// cfg_ready is always high. Reset restores the register defaults and clears
// the servo state; no clearing pass is needed.
//
module clock_slave_pi_servo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cspi_pkg::cspi_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cspi_pkg::cspi_out_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cspi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cspi_pkg::LIMIT_W-1:0]      cfg_data
);
    import cspi_pkg::*;

    // sequencer states
    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_DISP     = 5'd1;
    localparam logic [4:0] ST_PROJ     = 5'd2;
    localparam logic [4:0] ST_ERR      = 5'd3;
    localparam logic [4:0] ST_FREQ     = 5'd4;
    localparam logic [4:0] ST_BL_F     = 5'd5;
    localparam logic [4:0] ST_BL_F2    = 5'd6;
    localparam logic [4:0] ST_BL_A     = 5'd7;
    localparam logic [4:0] ST_BL_A2    = 5'd8;
    localparam logic [4:0] ST_STEP_MUL = 5'd9;
    localparam logic [4:0] ST_STEP_DIV = 5'd10;
    localparam logic [4:0] ST_P_MUL    = 5'd11;
    localparam logic [4:0] ST_P_DIV    = 5'd12;
    localparam logic [4:0] ST_I_MUL    = 5'd13;
    localparam logic [4:0] ST_I_DIV    = 5'd14;
    localparam logic [4:0] ST_RATE     = 5'd15;
    localparam logic [4:0] ST_DUR      = 5'd16;
    localparam logic [4:0] ST_FIN      = 5'd17;

    localparam int IW = 66;   // integrator arithmetic width
    localparam int CW = 58;   // correction arithmetic width
    localparam int RW = 45;   // new-rate arithmetic width

    // floor quotient saturated to a cap
    function automatic logic [TIME_W-1:0] sat_quo(input logic [PROD_W-1:0] q,
                                                  input logic [TIME_W-1:0] cap);
        logic over;
        over = (|q[PROD_W-1:TIME_W]) || (q[TIME_W-1:0] > cap);
        return over ? cap : q[TIME_W-1:0];
    endfunction

    // ---------------------------------------------------------------- state
    logic [4:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    cspi_out_t           out_data_reg, out_data_next;
    cspi_in_t            item_reg, item_next;

    logic [GAIN_W-1:0]   prop_gain_reg, integ_gain_reg;
    logic [WEIGHT_W-1:0] smooth_weight_reg;
    logic [LIMIT_W-1:0]  integ_limit_reg, corr_limit_reg;

    logic                seeded_reg, seeded_next;
    logic [TIME_W-1:0]   prev_master_reg, prev_master_next;
    logic [TIME_W-1:0]   prev_ref_reg, prev_ref_next;
    logic [TIME_W-1:0]   base_slave_reg, base_slave_next;
    logic [TIME_W-1:0]   base_ref_reg, base_ref_next;
    logic [RATIO_W-1:0]  rate_reg, rate_next;
    logic [RATIO_W-1:0]  fratio_reg, fratio_next;
    logic signed [ERR_W-1:0] integ_reg, integ_next;
    logic [ERR_W-1:0]    avg_err_reg, avg_err_next;
    logic [ERR_W-1:0]    peak_err_reg, peak_err_next;

    // working registers of one item
    logic                proj_neg_reg, proj_neg_next;
    logic [TIME_W-1:0]   cs_reg, cs_next;
    logic                neg_reg, neg_next;
    logic [ERR_W-1:0]    mag_reg, mag_next;
    logic                bl_neg_reg, bl_neg_next;
    logic [ERR_W-1:0]    bl_mag_reg, bl_mag_next;
    logic [TIME_W-1:0]   bl_prod_reg, bl_prod_next;
    logic [54:0]         pterm_reg, pterm_next;
    logic signed [RATIO_W-1:0] corr_reg, corr_next;
    logic [TIME_W-1:0]   res_st_reg, res_st_next;
    logic [TIME_W-1:0]   res_rd_reg, res_rd_next;
    logic                res_applied_reg, res_applied_next;

    // shared arithmetic units
    logic                mul_start, div_start;
    logic [TIME_W-1:0]   mul_a, mul_b, div_den;
    logic [PROD_W-1:0]   mul_prod, div_num, div_quo;
    cspi_stat_t          mul_stat, div_stat;

    cspi_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    cspi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // ------------------------------------------------------ datapath terms
    logic [TIME_W-1:0]   proj_a, proj_d, proj_cs, dm, dr;
    logic [TIME_W:0]     proj_sum;
    logic                r_ge, advance;
    logic                err_neg;
    logic [TIME_W-1:0]   err_diff;
    logic [ERR_W-1:0]    err_mag;
    logic [RATIO_W-1:0]  freq;
    logic [TIME_W-1:0]   bl_prod_c;
    logic [TIME_W:0]     bl_dec_sum;
    logic [ERR_W-1:0]    bl_old, bl_new;
    logic [62:0]         step;
    logic signed [IW-1:0] integ_sum, integ_lim;
    logic [ERR_W-1:0]    imag;
    logic [54:0]         iterm;
    logic signed [CW-1:0] corr_sum, corr_lim;
    logic signed [RW-1:0] rate_sum;

    // move of the slave time from the base, rounded toward zero
    assign r_ge     = item_reg.ref_time >= base_ref_reg;
    assign proj_a   = r_ge ? item_reg.ref_time - base_ref_reg
                           : base_ref_reg - item_reg.ref_time;
    assign proj_d   = (|mul_prod[PROD_W-1:TIME_W+FRAC_BITS]) ? TIME_MAX
                    : mul_prod[TIME_W+FRAC_BITS-1:FRAC_BITS];
    assign proj_sum = {1'b0, base_slave_reg} + {1'b0, proj_d};
    assign proj_cs  = proj_neg_reg
                    ? ((proj_d > base_slave_reg) ? '0 : base_slave_reg - proj_d)
                    : (proj_sum[TIME_W] ? TIME_MAX : proj_sum[TIME_W-1:0]);

    assign dm      = item_reg.master_time - prev_master_reg;
    assign dr      = item_reg.ref_time - prev_ref_reg;
    assign advance = (item_reg.master_time > prev_master_reg)
                  && (item_reg.ref_time > prev_ref_reg);

    // phase error against the projected slave time
    assign err_neg  = item_reg.master_time < cs_reg;
    assign err_diff = err_neg ? cs_reg - item_reg.master_time
                              : item_reg.master_time - cs_reg;
    assign err_mag  = (err_diff > ERR_CAP) ? ERR_CAP[ERR_W-1:0] : err_diff[ERR_W-1:0];

    assign freq = RATIO_W'(sat_quo(div_quo, RATIO_CAP));

    // averaging: old + floor((new - old) * w / 2^16)
    assign bl_prod_c  = bl_mag_reg * smooth_weight_reg;
    assign bl_dec_sum = {1'b0, bl_prod_reg} + (TIME_W + 1)'(16'hFFFF);
    assign bl_old     = (state_reg == ST_BL_F2) ? ERR_W'(fratio_reg) : avg_err_reg;
    assign bl_new     = bl_neg_reg ? bl_old - bl_dec_sum[ERR_W+WEIGHT_W-1:WEIGHT_W]
                                   : bl_old + bl_prod_reg[ERR_W+WEIGHT_W-1:WEIGHT_W];

    // integrator step and clamp
    assign step      = 63'(sat_quo(div_quo, STEP_CAP));
    assign integ_lim = IW'(integ_limit_reg);
    assign integ_sum = neg_reg ? IW'(integ_reg) - IW'(step) : IW'(integ_reg) + IW'(step);
    assign imag      = integ_reg[ERR_W-1] ? ERR_W'(-integ_reg) : ERR_W'(integ_reg);

    // proportional plus integral correction, clamped
    assign iterm    = 55'(sat_quo(div_quo, TERM_CAP));
    assign corr_lim = CW'(corr_limit_reg);
    assign corr_sum = (neg_reg ? -CW'(pterm_reg) : CW'(pterm_reg))
                    + (integ_reg[ERR_W-1] ? -CW'(iterm) : CW'(iterm));

    assign rate_sum = RW'(fratio_reg) + RW'(corr_reg);

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        item_next        = item_reg;
        seeded_next      = seeded_reg;
        prev_master_next = prev_master_reg;
        prev_ref_next    = prev_ref_reg;
        base_slave_next  = base_slave_reg;
        base_ref_next    = base_ref_reg;
        rate_next        = rate_reg;
        fratio_next      = fratio_reg;
        integ_next       = integ_reg;
        avg_err_next     = avg_err_reg;
        peak_err_next    = peak_err_reg;
        proj_neg_next    = proj_neg_reg;
        cs_next          = cs_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        bl_neg_next      = bl_neg_reg;
        bl_mag_next      = bl_mag_reg;
        bl_prod_next     = bl_prod_reg;
        pterm_next       = pterm_reg;
        corr_next        = corr_reg;
        res_st_next      = res_st_reg;
        res_rd_next      = res_rd_reg;
        res_applied_next = res_applied_reg;
        mul_start        = 1'b0;
        mul_a            = TIME_W'(mag_reg);
        mul_b            = dr;
        div_start        = 1'b0;
        div_num          = {mul_prod[PROD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_den          = GAIN_DIV;

        // drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_DISP;
                end
            end

            ST_DISP:
            begin
                res_st_next      = '0;
                res_rd_next      = '0;
                res_applied_next = 1'b0;
                proj_neg_next    = !r_ge;
                if (item_reg.mode == MODE_SAMPLE && !seeded_reg)
                begin
                    // first sample only seeds the timescale
                    seeded_next     = 1'b1;
                    base_slave_next = item_reg.master_time;
                    base_ref_next   = item_reg.ref_time;
                    res_st_next     = item_reg.master_time;
                    state_next      = ST_FIN;
                end
                else if (item_reg.mode == MODE_SAMPLE || item_reg.mode == MODE_READ)
                begin
                    mul_start  = 1'b1;
                    mul_a      = proj_a;
                    mul_b      = TIME_W'(rate_reg);
                    state_next = ST_PROJ;
                end
                else if (item_reg.mode == MODE_CONVERT)
                begin
                    if (rate_reg == '0)
                    begin
                        res_rd_next = item_reg.duration;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = {{(PROD_W-TIME_W-FRAC_BITS){1'b0}},
                                      item_reg.duration, {FRAC_BITS{1'b0}}};
                        div_den    = TIME_W'(rate_reg);
                        state_next = ST_DUR;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_PROJ:
            begin
                if (mul_stat.done)
                begin
                    cs_next     = proj_cs;
                    res_st_next = proj_cs;
                    if (item_reg.mode == MODE_SAMPLE && advance)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_ERR:
            begin
                neg_next   = err_neg;
                mag_next   = err_mag;
                div_start  = 1'b1;
                div_num    = {{(PROD_W-TIME_W-FRAC_BITS){1'b0}}, dm, {FRAC_BITS{1'b0}}};
                div_den    = dr;
                state_next = ST_FREQ;
            end

            ST_FREQ:
            begin
                if (div_stat.done)
                begin
                    bl_neg_next = freq < fratio_reg;
                    bl_mag_next = (freq < fratio_reg) ? ERR_W'(fratio_reg - freq)
                                                      : ERR_W'(freq - fratio_reg);
                    state_next  = ST_BL_F;
                end
            end

            ST_BL_F:
            begin
                bl_prod_next = bl_prod_c;
                state_next   = ST_BL_F2;
            end

            ST_BL_F2:
            begin
                fratio_next = RATIO_W'(bl_new);
                bl_neg_next = mag_reg < avg_err_reg;
                bl_mag_next = (mag_reg < avg_err_reg) ? avg_err_reg - mag_reg
                                                      : mag_reg - avg_err_reg;
                state_next  = ST_BL_A;
            end

            ST_BL_A:
            begin
                bl_prod_next = bl_prod_c;
                state_next   = ST_BL_A2;
            end

            ST_BL_A2:
            begin
                avg_err_next = bl_new;
                if (mag_reg > peak_err_reg)
                begin
                    peak_err_next = mag_reg;
                end
                mul_start  = 1'b1;
                state_next = ST_STEP_MUL;
            end

            ST_STEP_MUL:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    div_num    = mul_prod;
                    div_den    = NS_PER_S;
                    state_next = ST_STEP_DIV;
                end
            end

            ST_STEP_DIV:
            begin
                if (div_stat.done)
                begin
                    if (integ_sum > integ_lim)
                    begin
                        integ_next = ERR_W'(integ_lim);
                    end
                    else if (integ_sum < -integ_lim)
                    begin
                        integ_next = ERR_W'(-integ_lim);
                    end
                    else
                    begin
                        integ_next = ERR_W'(integ_sum);
                    end
                    mul_start  = 1'b1;
                    mul_b      = TIME_W'(prop_gain_reg);
                    state_next = ST_P_MUL;
                end
            end

            ST_P_MUL:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_P_DIV;
                end
            end

            ST_P_DIV:
            begin
                if (div_stat.done)
                begin
                    pterm_next = 55'(sat_quo(div_quo, TERM_CAP));
                    mul_start  = 1'b1;
                    mul_a      = TIME_W'(imag);
                    mul_b      = TIME_W'(integ_gain_reg);
                    state_next = ST_I_MUL;
                end
            end

            ST_I_MUL:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_I_DIV;
                end
            end

            ST_I_DIV:
            begin
                if (div_stat.done)
                begin
                    if (corr_sum > corr_lim)
                    begin
                        corr_next = RATIO_W'(corr_lim);
                    end
                    else if (corr_sum < -corr_lim)
                    begin
                        corr_next = RATIO_W'(-corr_lim);
                    end
                    else
                    begin
                        corr_next = RATIO_W'(corr_sum);
                    end
                    state_next = ST_RATE;
                end
            end

            ST_RATE:
            begin
                // set the new rate and rebase at this sample
                if (rate_sum < 0)
                begin
                    rate_next = '0;
                end
                else if (rate_sum > RW'(RATIO_CAP))
                begin
                    rate_next = RATIO_CAP[RATIO_W-1:0];
                end
                else
                begin
                    rate_next = RATIO_W'(rate_sum);
                end
                base_slave_next  = cs_reg;
                base_ref_next    = item_reg.ref_time;
                res_applied_next = 1'b1;
                state_next       = ST_FIN;
            end

            ST_DUR:
            begin
                if (div_stat.done)
                begin
                    res_rd_next = sat_quo(div_quo, TIME_MAX);
                    state_next  = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (item_reg.mode == MODE_SAMPLE)
                begin
                    prev_master_next = item_reg.master_time;
                    prev_ref_next    = item_reg.ref_time;
                end
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.slave_time    = res_st_reg;
                    out_data_next.ref_duration  = res_rd_reg;
                    out_data_next.rate_now      = rate_reg;
                    out_data_next.jitter_ns     = avg_err_reg;
                    out_data_next.max_error_ns  = peak_err_reg;
                    out_data_next.applied       = res_applied_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, servo state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            seeded_reg        <= 1'b0;
            prev_master_reg   <= '0;
            prev_ref_reg      <= '0;
            base_slave_reg    <= '0;
            base_ref_reg      <= '0;
            rate_reg          <= ONE_RATIO;
            fratio_reg        <= ONE_RATIO;
            integ_reg         <= '0;
            avg_err_reg       <= '0;
            peak_err_reg      <= '0;
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            smooth_weight_reg <= SMOOTH_WEIGHT_RST;
            integ_limit_reg   <= INTEG_LIMIT_RST;
            corr_limit_reg    <= CORR_LIMIT_RST;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            seeded_reg      <= seeded_next;
            prev_master_reg <= prev_master_next;
            prev_ref_reg    <= prev_ref_next;
            base_slave_reg  <= base_slave_next;
            base_ref_reg    <= base_ref_next;
            rate_reg        <= rate_next;
            fratio_reg      <= fratio_next;
            integ_reg       <= integ_next;
            avg_err_reg     <= avg_err_next;
            peak_err_reg    <= peak_err_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_SMOOTH_WEIGHT: smooth_weight_reg <= cfg_data[WEIGHT_W-1:0];
                    REG_INTEG_LIMIT:   integ_limit_reg   <= cfg_data;
                    REG_CORR_LIMIT:    corr_limit_reg    <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
        item_reg        <= item_next;
        proj_neg_reg    <= proj_neg_next;
        cs_reg          <= cs_next;
        neg_reg         <= neg_next;
        mag_reg         <= mag_next;
        bl_neg_reg      <= bl_neg_next;
        bl_mag_reg      <= bl_mag_next;
        bl_prod_reg     <= bl_prod_next;
        pterm_reg       <= pterm_next;
        corr_reg        <= corr_next;
        res_st_reg      <= res_st_next;
        res_rd_reg      <= res_rd_next;
        res_applied_reg <= res_applied_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // one item at a time: no new item right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is in work");

    // the multiplier and divider are never run together
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy at once");

    // a loop update only follows seeding
    a_applied_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.applied |-> seeded_reg)
        else $error("loop update reported before seeding");
`endif

endmodule

// ===== rtl/core/cspi_mul.sv =====
// ----------------------------------------------------------------------------
// cspi_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle; full double-width product.
// ----------------------------------------------------------------------------
module cspi_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cspi_pkg::TIME_W-1:0]   a,
    input  logic [cspi_pkg::TIME_W-1:0]   b,
    output logic [cspi_pkg::PROD_W-1:0]   product,
    output cspi_pkg::cspi_stat_t          stat
);
    import cspi_pkg::*;

    localparam int CNT_W = $clog2(TIME_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(TIME_W);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

    logic [TIME_W-1:0] hi_reg, hi_next;
    logic [TIME_W-1:0] lo_reg, lo_next;
    logic [TIME_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(TIME_W + 1){1'b0}});

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = b;
            a_next    = a;
            cnt_next  = STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add, then shift the partial product one place right
            hi_next  = sum[TIME_W:1];
            lo_next  = {sum[0], lo_reg[TIME_W-1:1]};
            cnt_next = cnt_reg - LAST;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/cspi_div.sv =====
// ----------------------------------------------------------------------------
// cspi_div: bit-serial restoring divider
// Double-width dividend, single-width divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cspi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cspi_pkg::PROD_W-1:0]   num,
    input  logic [cspi_pkg::TIME_W-1:0]   den,
    output logic [cspi_pkg::PROD_W-1:0]   quo,
    output cspi_pkg::cspi_stat_t          stat
);
    import cspi_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(PROD_W);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

    logic [PROD_W-1:0] nq_reg, nq_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   diff;
    logic              ge;

    assign shifted = {rem_reg, nq_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            nq_next   = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // bring in the next dividend bit, subtract when it fits
            rem_next = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            nq_next  = {nq_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg - LAST;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo       = nq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== tb/sv/clock_slave_pi_servo_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_slave_pi_servo_test: self-checking bench of the PI clock servo
// Drives sample, read and conversion items through the valid/ready channels,
// keeps a bit-exact servo model of its own and compares every output item
// field by field, across several gain and limit settings and idling patterns.
// ----------------------------------------------------------------------------
module clock_slave_pi_servo_test;
    import cspi_pkg::*;

    localparam int DRAIN_CYCLES = 1000;      // longer than one loop update
    localparam int CYCLE_LIMIT  = 6000000;
    localparam logic [63:0] PHASE_ITEMS = 64'd200;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    cspi_in_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    cspi_out_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;

    clock_slave_pi_servo uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Servo model: registers and loop state, mirrored from the block.
    bit [23:0]   m_prop_gain;
    bit [23:0]   m_integ_gain;
    bit [15:0]   m_weight;
    bit [40:0]   m_integ_lim;
    bit [40:0]   m_corr_lim;
    bit          m_seeded;
    bit [63:0]   m_prev_master;
    bit [63:0]   m_prev_ref;
    bit [63:0]   m_base_slave;
    bit [63:0]   m_base_ref;
    bit [63:0]   m_rate;
    bit [63:0]   m_ratio;
    longint      m_integ;
    bit [63:0]   m_avg_err;
    bit [63:0]   m_peak_err;

    // Expected output items, oldest first, plus typed-in overrides per item.
    cspi_out_t   servo_out_q[$];
    bit          typed_flag_q[$];
    cspi_out_t   typed_out_q[$];

    int          send_pct;
    int          recv_pct;
    int          errors;
    int          cycles;
    int          n_items;
    int          n_results;
    int          n_updates;
    int          n_cfg;
    bit [63:0]   cur_master;
    bit [63:0]   cur_ref;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: end the run if something hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycles, servo_out_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // floor(n / d) saturated to cap; d nonzero
    function automatic bit [63:0] sat_div(bit [127:0] n, bit [63:0] d, bit [63:0] cap);
        bit [127:0] q;
        q = n / {64'd0, d};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    // Slave time at reference time r from the current base and rate.
    function automatic bit [63:0] slave_at(bit [63:0] r);
        bit [127:0] span;
        bit [127:0] prod;
        bit [63:0]  d;
        span = (r >= m_base_ref) ? {64'd0, r - m_base_ref} : {64'd0, m_base_ref - r};
        prod = (span * {64'd0, m_rate}) >> FRAC_BITS;
        d = (prod > {64'd0, TIME_MAX}) ? TIME_MAX : prod[63:0];
        if (r >= m_base_ref)
            return (d > TIME_MAX - m_base_slave) ? TIME_MAX : m_base_slave + d;
        return (d > m_base_slave) ? 64'd0 : m_base_slave - d;
    endfunction

    // Weighted average; 64-bit wraparound kept on purpose to match hardware width.
    function automatic bit [63:0] smooth(bit [63:0] prev, bit [63:0] nv);
        bit [63:0] w;
        w = {48'd0, m_weight};
        return (prev * (64'd65536 - w) + nv * w) >> 16;
    endfunction

    function automatic longint gain_term(bit [63:0] mag, bit neg, bit [23:0] gain);
        bit [127:0] n;
        longint     v;
        n = ({64'd0, mag} * {104'd0, gain}) << FRAC_BITS;
        v = longint'(sat_div(n, GAIN_DIV, TERM_CAP));
        return neg ? -v : v;
    endfunction

    task automatic servo_update(bit [63:0] m, bit [63:0] r, bit [63:0] cs);
        bit [63:0] dm;
        bit [63:0] dr;
        bit [63:0] freq;
        bit [63:0] mag;
        bit [63:0] stp;
        bit [63:0] imag;
        bit        neg;
        longint    lim;
        longint    corr;
        longint    nr;
        dm = m - m_prev_master;
        dr = r - m_prev_ref;
        freq = sat_div({64'd0, dm} << FRAC_BITS, dr, RATIO_CAP);
        neg = m < cs;
        mag = neg ? cs - m : m - cs;
        if (mag > ERR_CAP)
            mag = ERR_CAP;
        m_ratio = smooth(m_ratio, freq);
        m_avg_err = smooth(m_avg_err, mag);
        if (mag > m_peak_err)
            m_peak_err = mag;
        stp = sat_div({64'd0, mag} * {64'd0, dr}, NS_PER_S, STEP_CAP);
        m_integ = neg ? m_integ - longint'(stp) : m_integ + longint'(stp);
        lim = longint'({23'd0, m_integ_lim});
        if (m_integ > lim)
            m_integ = lim;
        if (m_integ < -lim)
            m_integ = -lim;
        imag = (m_integ < 0) ? 64'(-m_integ) : 64'(m_integ);
        corr = gain_term(mag, neg, m_prop_gain) + gain_term(imag, m_integ < 0, m_integ_gain);
        lim = longint'({23'd0, m_corr_lim});
        if (corr > lim)
            corr = lim;
        if (corr < -lim)
            corr = -lim;
        nr = longint'(m_ratio) + corr;
        if (nr < 0)
            nr = 0;
        if (nr > longint'(RATIO_CAP))
            nr = longint'(RATIO_CAP);
        m_rate = 64'(nr);
        m_base_slave = cs;
        m_base_ref = r;
    endtask

    // Work out the output item for one accepted input item, advancing the model.
    task automatic servo_predict(cspi_in_t it, output cspi_out_t res);
        bit [63:0] st;
        bit [63:0] rd;
        bit        upd;
        st = 64'd0;
        rd = 64'd0;
        upd = 1'b0;
        case (it.mode)
            MODE_SAMPLE:
            begin
                if (!m_seeded)
                begin
                    m_seeded = 1'b1;
                    m_base_slave = it.master_time;
                    m_base_ref = it.ref_time;
                    st = it.master_time;
                end
                else
                begin
                    st = slave_at(it.ref_time);
                    if (it.master_time > m_prev_master && it.ref_time > m_prev_ref)
                    begin
                        servo_update(it.master_time, it.ref_time, st);
                        upd = 1'b1;
                    end
                end
                m_prev_master = it.master_time;
                m_prev_ref = it.ref_time;
            end
            MODE_READ:
                st = slave_at(it.ref_time);
            MODE_CONVERT:
                rd = (m_rate == 64'd0) ? it.duration
                     : sat_div({64'd0, it.duration} << FRAC_BITS, m_rate, TIME_MAX);
            default:
                ;
        endcase
        res.slave_time   = st;
        res.ref_duration = rd;
        res.rate_now     = m_rate[RATIO_W-1:0];
        res.jitter_ns    = m_avg_err[ERR_W-1:0];
        res.max_error_ns = m_peak_err[ERR_W-1:0];
        res.applied      = upd;
    endtask

    // Input side monitor: apply register writes and predict accepted items.
    always @(posedge clk)
    begin
        cspi_out_t res;
        cspi_out_t typed;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            n_cfg <= n_cfg + 1;
            case (cfg_index)
                REG_PROP_GAIN:     m_prop_gain  = cfg_data[23:0];
                REG_INTEG_GAIN:    m_integ_gain = cfg_data[23:0];
                REG_SMOOTH_WEIGHT: m_weight     = cfg_data[15:0];
                REG_INTEG_LIMIT:   m_integ_lim  = cfg_data;
                REG_CORR_LIMIT:    m_corr_lim   = cfg_data;
                default:           ;
            endcase
        end
        if (rst_n && in_valid && in_ready)
        begin
            n_items <= n_items + 1;
            servo_predict(in_data, res);
            typed = typed_out_q.pop_front();
            // a typed-in row takes the place of the model's answer
            servo_out_q.push_back(typed_flag_q.pop_front() ? typed : res);
        end
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch at %0t on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Output side: random stalls, and compare against the oldest expectation.
    always @(posedge clk)
    begin
        cspi_out_t want;
        out_ready <= ($urandom_range(99) >= recv_pct);
        if (rst_n && out_valid && out_ready)
        begin
            n_results <= n_results + 1;
            if (servo_out_q.size() == 0)
            begin
                report("unexpected item", out_data.slave_time, 64'd0);
            end
            else
            begin
                want = servo_out_q.pop_front();
                if (out_data.applied)
                    n_updates <= n_updates + 1;
                if (out_data.slave_time !== want.slave_time)
                    report("slave_time", out_data.slave_time, want.slave_time);
                if (out_data.ref_duration !== want.ref_duration)
                    report("ref_duration", out_data.ref_duration, want.ref_duration);
                if (out_data.rate_now !== want.rate_now)
                    report("rate_now", out_data.rate_now, want.rate_now);
                if (out_data.jitter_ns !== want.jitter_ns)
                    report("jitter_ns", out_data.jitter_ns, want.jitter_ns);
                if (out_data.max_error_ns !== want.max_error_ns)
                    report("max_error_ns", out_data.max_error_ns, want.max_error_ns);
                if (out_data.applied !== want.applied)
                    report("applied", out_data.applied, want.applied);
            end
        end
    end

    // Offer one item; hold it until accepted. Idle first at random.
    task automatic send_item(cspi_in_t it, bit typed, cspi_out_t typed_res);
        if ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_pct);
        end
        typed_flag_q.push_back(typed);
        typed_out_q.push_back(typed_res);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send(logic [1:0] mode, bit [63:0] m, bit [63:0] r, bit [63:0] dur);
        cspi_in_t it;
        it = '{mode: mode, master_time: m, ref_time: r, duration: dur};
        send_item(it, 1'b0, '0);
    endtask

    // Hold the sender until every expected item is back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (servo_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [40:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(bit [23:0] pg, bit [23:0] ig, bit [15:0] w,
                             bit [40:0] il, bit [40:0] cl);
        write_reg(REG_PROP_GAIN, {17'd0, pg});
        write_reg(REG_INTEG_GAIN, {17'd0, ig});
        write_reg(REG_SMOOTH_WEIGHT, {25'd0, w});
        write_reg(REG_INTEG_LIMIT, il);
        write_reg(REG_CORR_LIMIT, cl);
    endtask

    // One random item; mostly a well-formed stream of advancing samples.
    task automatic random_item();
        int        roll;
        bit [63:0] dr;
        bit [63:0] dm;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            if ($urandom_range(19) == 0)
            begin
                dr = 64'($urandom_range(1000, 1));
                dm = {32'd0, $urandom} + 64'd1;
            end
            else
            begin
                dr = 64'd999000000 + 64'($urandom_range(2000000));
                dm = dr + 64'($urandom_range(200000)) - 64'd100000;
            end
            cur_master += dm;
            cur_ref += dr;
            send(MODE_SAMPLE, cur_master, cur_ref, rand64());
        end
        else if (roll < 70)
        begin
            send(MODE_READ, rand64(),
                 $urandom_range(1) ? cur_ref + 64'($urandom) : cur_ref - 64'($urandom),
                 rand64());
        end
        else if (roll < 82)
        begin
            send(MODE_CONVERT, rand64(), rand64(),
                 $urandom_range(1) ? rand64() : {32'd0, $urandom});
        end
        else if (roll < 88)
        begin
            // sample that does not advance one of the clocks
            send(MODE_SAMPLE, $urandom_range(1) ? cur_master : cur_master + 64'd5,
                 cur_ref - 64'($urandom_range(3)), rand64());
        end
        else if (roll < 96)
        begin
            send(2'($urandom_range(2)), rand64(), rand64(), rand64());
        end
        else
        begin
            send(2'd3, rand64(), rand64(), rand64());
        end
    endtask

    function automatic cspi_out_t fresh(bit [63:0] st, bit [63:0] rd);
        cspi_out_t o;
        o = '0;
        o.slave_time = st;
        o.ref_duration = rd;
        o.rate_now = ONE_RATIO;
        return o;
    endfunction

    typedef struct {
        cspi_in_t  stim;
        bit        typed;
        cspi_out_t res;
    } row_t;

    initial
    begin
        row_t      rows[$];
        cspi_in_t  it;
        bit [63:0] tmax;
        int        phase;
        int        k;
        tmax = TIME_MAX;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        errors = 0;
        cycles = 0;
        n_items = 0;
        n_results = 0;
        n_updates = 0;
        n_cfg = 0;
        send_pct = 27;
        recv_pct = 51;
        m_prop_gain = PROP_GAIN_RST;
        m_integ_gain = INTEG_GAIN_RST;
        m_weight = SMOOTH_WEIGHT_RST;
        m_integ_lim = INTEG_LIMIT_RST;
        m_corr_lim = CORR_LIMIT_RST;
        m_seeded = 1'b0;
        m_prev_master = 0;
        m_prev_ref = 0;
        m_base_slave = 0;
        m_base_ref = 0;
        m_rate = 64'(ONE_RATIO);
        m_ratio = 64'(ONE_RATIO);
        m_integ = 0;
        m_avg_err = 0;
        m_peak_err = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset state, extremes, seeding and special cases.
        rows = '{
            // read before seeding, at both ends of the reference
            '{'{MODE_READ, 64'd0, 64'd0, 64'd0}, 1'b1, fresh(64'd0, 64'd0)},
            '{'{MODE_READ, tmax, tmax, tmax}, 1'b1, fresh(tmax, 64'd0)},
            // conversion at unit rate
            '{'{MODE_CONVERT, 64'd0, 64'd0, 64'd0}, 1'b1, fresh(64'd0, 64'd0)},
            '{'{MODE_CONVERT, 64'd0, 64'd0, tmax}, 1'b1, fresh(64'd0, tmax)},
            // unused selector leaves everything alone
            '{'{2'd3, tmax, tmax, tmax}, 1'b1, fresh(64'd0, 64'd0)},
            // first sample seeds the bases
            '{'{MODE_SAMPLE, 64'd1000, 64'd500, 64'd0}, 1'b1, fresh(64'd1000, 64'd0)},
            // master did not advance: projection only
            '{'{MODE_SAMPLE, 64'd1000, 64'd600, 64'd0}, 1'b1, fresh(64'd1100, 64'd0)},
            '{'{MODE_SAMPLE, 64'd1000001000, 64'd1000000600, 64'd0}, 1'b0, '0},
            '{'{MODE_SAMPLE, 64'd2000001900, 64'd2000000600, 64'd0}, 1'b0, '0},
            '{'{MODE_SAMPLE, 64'd3000000000, 64'd3000000600, 64'd0}, 1'b0, '0},
            '{'{MODE_READ, 64'd0, 64'd3500000000, 64'd0}, 1'b0, '0},
            '{'{MODE_READ, 64'd0, 64'd0, 64'd0}, 1'b0, '0},
            '{'{MODE_CONVERT, 64'd0, 64'd0, 64'd123456789}, 1'b0, '0},
            // huge phase error saturates error and integrator
            '{'{MODE_SAMPLE, tmax, tmax, 64'd0}, 1'b0, '0},
            '{'{MODE_READ, 64'd0, 64'd0, 64'd0}, 1'b0, '0},
            '{'{MODE_CONVERT, 64'd0, 64'd0, tmax}, 1'b0, '0},
            // reference went backwards: no update; the next sample advances both clocks
            '{'{MODE_SAMPLE, 64'd10, 64'd10, 64'd0}, 1'b0, '0},
            '{'{MODE_SAMPLE, 64'd1000000010, 64'd20, 64'd0}, 1'b0, '0},
            '{'{2'd3, 64'd0, 64'd0, 64'd0}, 1'b0, '0}
        };
        foreach (rows[i])
            send_item(rows[i].stim, rows[i].typed, rows[i].res);

        // Drive the rate to zero: full weight on a near-zero ratio, no correction.
        drain();
        write_all(24'd0, 24'd0, 16'hFFFF, 41'd0, 41'd0);
        cur_master = 64'd100;
        cur_ref = 64'd100;
        send(MODE_SAMPLE, cur_master, cur_ref, 64'd0);
        for (k = 0; k < 4; k++)
        begin
            cur_master += 64'd1;
            cur_ref += 64'd1 << 50;
            send(MODE_SAMPLE, cur_master, cur_ref, 64'd0);
            // tiny rate: division overflows, then zero rate passes it through
            send(MODE_CONVERT, 64'd0, 64'd0, tmax);
            send(MODE_CONVERT, 64'd0, 64'd0, 64'd987654321);
        end

        // Random phases: three idling patterns, two register settings each.
        for (phase = 0; phase < 6; phase++)
        begin
            drain();
            send_pct = (phase < 2) ? 27 : (phase < 4) ? 51 : 0;
            recv_pct = (phase < 2) ? 51 : (phase < 4) ? 27 : 0;
            case (phase)
                0: write_all(PROP_GAIN_RST, INTEG_GAIN_RST, SMOOTH_WEIGHT_RST,
                             INTEG_LIMIT_RST, CORR_LIMIT_RST);
                1: write_all(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
                             41'h100_0000_0000, 41'h100_0000_0000);
                2: write_all(24'd0, 24'd0, 16'd0, 41'd0, 41'd0);
                4: write_all(24'hFFFFFF, 24'd1, 16'd1, 41'h1FF_FFFF_FFFF, 41'h1FF_FFFF_FFFF);
                default: write_all(24'($urandom), 24'($urandom), 16'($urandom),
                                   41'(rand64()), 41'(rand64()));
            endcase
            // anchor the stream somewhere new; the second sample does not advance the master
            cur_master = {24'd0, rand64() >> 24};
            cur_ref = cur_master + 64'($urandom_range(1000000));
            send(MODE_SAMPLE, cur_master, cur_ref - 64'd1, 64'd0);
            send(MODE_SAMPLE, cur_master, cur_ref, 64'd0);
            for (k = 0; k < int'(PHASE_ITEMS); k++)
                random_item();
        end

        drain();
        $display("covered %0d items, %0d output items, %0d loop updates, %0d register writes",
                 n_items, n_results, n_updates, n_cfg);
        $display("six random phases over three idling patterns; %0d mismatches", errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cspi_pkg.sv
rtl/core/cspi_mul.sv
rtl/core/cspi_div.sv
rtl/core/clock_slave_pi_servo.sv
tb/sv/clock_slave_pi_servo_test.sv
